/* rtl/tcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // multiplier operand slice and pipeline depth
  localparam int MUL_CHUNK = 32;
  localparam int MUL_LAT   = 3;

endpackage

`default_nettype wire

/* rtl/tcc_delay.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcc_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

`default_nettype wire

/* rtl/tcc_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcc_mul import tcc_pkg::*; #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int NA  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AXW = NA * MUL_CHUNK;
  localparam int BXW = NB * MUL_CHUNK;
  localparam int RW  = (NB + 1) * MUL_CHUNK;
  localparam int SW  = (NA + NB) * MUL_CHUNK;

  logic [AXW-1:0]         ax;
  logic [BXW-1:0]         bx;
  logic [2*MUL_CHUNK-1:0] pp [NA][NB];
  logic [RW-1:0]          row [NA];
  logic [RW-1:0]          row_next [NA];
  logic [SW-1:0]          sum;
  logic [SW-1:0]          sum_next;

  assign ax = AXW'(a);
  assign bx = BXW'(b);

  // rows: one slice of a against all slices of b
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (RW'(pp[i][j]) << (j * MUL_CHUNK));
      end
    end
    sum_next = '0;
    for (int i = 0; i < NA; i++) begin
      sum_next = sum_next + (SW'(row[i]) << (i * MUL_CHUNK));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ax[i*MUL_CHUNK +: MUL_CHUNK] * bx[j*MUL_CHUNK +: MUL_CHUNK];
        end
        row[i] <= row_next[i];
      end
      sum <= sum_next;
    end
  end

  assign p = sum[AW+BW-1:0];

endmodule

`default_nettype wire

/* rtl/tcc_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcc_div #(
  parameter int NW = 104,
  parameter int DW = 72,
  parameter int QB = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo,
  output logic          big
);

  logic [DW-1:0] rm [QB+1];
  logic [DW-1:0] dv [QB+1];
  logic [QB-1:0] nl [QB+1];
  logic [QB-1:0] qt [QB+1];
  logic          bg [QB+1];

  // quotient too wide for QB bits when the top part already reaches den
  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= DW'(num >> QB);
      bg[0] <= (num >> QB) >= NW'(den);
      nl[0] <= num[QB-1:0];
      dv[0] <= den;
      qt[0] <= '0;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rm[k-1], nl[k-1][QB-1]};
    assign ge    = trial >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k] <= ge ? DW'(trial - {1'b0, dv[k-1]}) : DW'(trial);
        qt[k] <= {qt[k-1][QB-2:0], ge};
        nl[k] <= nl[k-1] << 1;
        dv[k] <= dv[k-1];
        bg[k] <= bg[k-1];
      end
    end
  end

  assign quo = qt[QB];
  assign big = bg[QB];

endmodule

`default_nettype wire

/* rtl/tcc_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcc_sqrt #(
  parameter int RB = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RB-1:0] s,
  output logic [RB-1:0]   root,
  output logic [2*RB-1:0] rem
);

  localparam int SW = 2 * RB;

  logic [SW-1:0] rm [RB];
  logic [RB-1:0] rt [RB];

  // one root bit per stage, rem tracks s - root^2
  for (genvar k = 0; k < RB; k++) begin : g_step
    localparam int B = RB - 1 - k;
    logic [SW-1:0] r_in;
    logic [RB-1:0] q_in;
    logic [SW-1:0] trial;

    if (k == 0) begin : g_first
      assign r_in = s;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rm[k-1];
      assign q_in = rt[k-1];
    end

    assign trial = (SW'(q_in) << (B + 1)) | (SW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (r_in >= trial) begin
          rm[k] <= r_in - trial;
          rt[k] <= q_in | (RB'(1) << B);
        end else begin
          rm[k] <= r_in;
          rt[k] <= q_in;
        end
      end
    end
  end

  assign root = rt[RB-1];
  assign rem  = rm[RB-1];

endmodule

`default_nettype wire

/* rtl/triangle_circumcircle.sv */
// Circumcircle of three points in signed fixed point. One word in per clock and
// one word out per clock while the result is not stalled. The pipe is mainly
// the restoring divider (one quotient bit per stage, COORD_WIDTH + 2 stages),
// the square root (one root bit per stage, COORD_WIDTH + 1 stages) and three
// multiplier passes.
// The whole pipeline holds while the result is stalled. Collinear or
// coincident points give zero center and radius with degenerate set.
// Centers outside the signed range and radii outside the unsigned range clamp
// and raise saturated.
`timescale 1ns / 1ps
`default_nettype none

module triangle_circumcircle import tcc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  output logic                          stall,
  input  logic signed [COORD_WIDTH-1:0] p1_x,
  input  logic signed [COORD_WIDTH-1:0] p1_y,
  input  logic signed [COORD_WIDTH-1:0] p2_x,
  input  logic signed [COORD_WIDTH-1:0] p2_y,
  input  logic signed [COORD_WIDTH-1:0] p3_x,
  input  logic signed [COORD_WIDTH-1:0] p3_y,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [COORD_WIDTH-1:0] center_x,
  output logic signed [COORD_WIDTH-1:0] center_y,
  output logic        [COORD_WIDTH-1:0] radius,
  output logic                          degenerate,
  output logic                          saturated
);

  localparam int W   = COORD_WIDTH;
  localparam int OW  = W + 1;
  localparam int EW  = 2 * OW + 2;
  localparam int BW2 = 2 * OW + 1;
  localparam int P2W = OW + BW2;
  localparam int SPW = P2W + 1;
  localparam int NXW = P2W + 2;
  localparam int NW  = NXW + 2;
  localparam int DW  = EW + 2;
  localparam int QB  = W + 1;
  localparam int QMW = W + 2;
  localparam int SMW = W + 3;
  localparam int RB  = W + 1;
  localparam int SW  = 2 * RB;
  localparam int GW  = 2 * W + 2;

  // register stage numbers along the pipe
  localparam int T_E1 = 3 + MUL_LAT;
  localparam int T_E2 = T_E1 + 1;
  localparam int T_P2 = T_E1 + MUL_LAT;
  localparam int T_S2 = T_P2 + 2;
  localparam int T_A  = T_P2 + 3;
  localparam int T_N  = T_P2 + 4;
  localparam int TQ   = T_N + QB + 1;
  localparam int T_G  = TQ + 2;
  localparam int TS   = TQ + 1 + MUL_LAT + 1 + RB;
  localparam int LAT  = TS + 1;

  localparam logic [QMW-1:0] QBIG = QMW'(1) << (W + 1);
  localparam logic [W-1:0]   CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   CMIN = {1'b1, {(W-1){1'b0}}};

  logic           en;
  logic [LAT-1:0] vld;

  assign en           = !(result_valid && result_stall);
  assign stall        = !en;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], valid};
    end
  end

  // offsets from the first point: 0 bx, 1 by, 2 cx, 3 cy
  logic signed [OW-1:0] off [4];
  logic signed [W-1:0]  x1;
  logic signed [W-1:0]  y1;

  always_ff @(posedge clk) begin
    if (en) begin
      off[0] <= OW'(p2_x) - OW'(p1_x);
      off[1] <= OW'(p2_y) - OW'(p1_y);
      off[2] <= OW'(p3_x) - OW'(p1_x);
      off[3] <= OW'(p3_y) - OW'(p1_y);
      x1     <= p1_x;
      y1     <= p1_y;
    end
  end

  logic [OW-1:0] mag [4];
  logic [3:0]    sgn;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mag[i] <= off[i][OW-1] ? OW'(-off[i]) : OW'(off[i]);
        sgn[i] <= off[i][OW-1];
      end
    end
  end

  // cross terms and squared lengths
  logic [OW-1:0]   m1_a [6];
  logic [OW-1:0]   m1_b [6];
  logic [2*OW-1:0] m1_p [6];

  assign m1_a = '{mag[0], mag[1], mag[0], mag[1], mag[2], mag[3]};
  assign m1_b = '{mag[3], mag[2], mag[0], mag[1], mag[2], mag[3]};

  for (genvar i = 0; i < 6; i++) begin : g_m1
    tcc_mul #(.AW(OW), .BW(OW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (m1_a[i]),
      .b   (m1_b[i]),
      .p   (m1_p[i])
    );
  end

  logic [3:0]      sgn_m1;
  logic [3:0]      sgn_m2;
  logic [4*OW-1:0] mag_d;
  logic [OW-1:0]   md [4];

  tcc_delay #(.WIDTH(4), .DEPTH(MUL_LAT)) u_sgn_m1 (
    .clk (clk), .en (en), .d (sgn), .q (sgn_m1)
  );

  tcc_delay #(.WIDTH(4), .DEPTH(T_P2 - 2)) u_sgn_m2 (
    .clk (clk), .en (en), .d (sgn), .q (sgn_m2)
  );

  tcc_delay #(.WIDTH(4 * OW), .DEPTH(T_E1 - 2)) u_mag (
    .clk (clk), .en (en), .d ({mag[3], mag[2], mag[1], mag[0]}), .q (mag_d)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      md[i] = mag_d[i*OW +: OW];
    end
  end

  logic signed [EW-1:0] ta;
  logic signed [EW-1:0] tb;
  logic [BW2-1:0]       bb;
  logic [BW2-1:0]       cc;
  logic signed [EW-1:0] e;

  always_ff @(posedge clk) begin
    if (en) begin
      ta <= (sgn_m1[0] ^ sgn_m1[3]) ? EW'(0) - EW'(m1_p[0]) : EW'(m1_p[0]);
      tb <= (sgn_m1[1] ^ sgn_m1[2]) ? EW'(0) - EW'(m1_p[1]) : EW'(m1_p[1]);
      bb <= BW2'(m1_p[2]) + BW2'(m1_p[3]);
      cc <= BW2'(m1_p[4]) + BW2'(m1_p[5]);
      e  <= ta - tb;
    end
  end

  // numerator products: cy*bb, by*cc, bx*cc, cx*bb
  logic [OW-1:0]  m2_a [4];
  logic [BW2-1:0] m2_b [4];
  logic [P2W-1:0] m2_p [4];

  assign m2_a = '{md[3], md[1], md[0], md[2]};
  assign m2_b = '{bb, cc, cc, bb};

  for (genvar i = 0; i < 4; i++) begin : g_m2
    tcc_mul #(.AW(OW), .BW(BW2)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (m2_a[i]),
      .b   (m2_b[i]),
      .p   (m2_p[i])
    );
  end

  logic signed [SPW-1:0] sp [4];
  logic signed [NXW-1:0] nx;
  logic signed [NXW-1:0] ny;
  logic signed [EW-1:0]  e_d;

  tcc_delay #(.WIDTH(EW), .DEPTH(T_S2 - T_E2)) u_e (
    .clk (clk), .en (en), .d (e), .q (e_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sp[0] <= sgn_m2[3] ? SPW'(0) - SPW'(m2_p[0]) : SPW'(m2_p[0]);
      sp[1] <= sgn_m2[1] ? SPW'(0) - SPW'(m2_p[1]) : SPW'(m2_p[1]);
      sp[2] <= sgn_m2[0] ? SPW'(0) - SPW'(m2_p[2]) : SPW'(m2_p[2]);
      sp[3] <= sgn_m2[2] ? SPW'(0) - SPW'(m2_p[3]) : SPW'(m2_p[3]);
      nx    <= NXW'(sp[0]) - NXW'(sp[1]);
      ny    <= NXW'(sp[2]) - NXW'(sp[3]);
    end
  end

  logic [NXW-1:0] anx;
  logic [NXW-1:0] any_;
  logic [EW-1:0]  ae;
  logic [1:0]     neg;
  logic           deg;
  logic [NW-1:0]  num_x;
  logic [NW-1:0]  num_y;
  logic [DW-1:0]  den;

  // rounded quotient: (2|n| + |d|) / (2|d|) with d = 2e
  always_ff @(posedge clk) begin
    if (en) begin
      anx   <= nx[NXW-1] ? NXW'(-nx) : NXW'(nx);
      any_  <= ny[NXW-1] ? NXW'(-ny) : NXW'(ny);
      ae    <= e_d[EW-1] ? EW'(-e_d) : EW'(e_d);
      neg   <= {ny[NXW-1] ^ e_d[EW-1], nx[NXW-1] ^ e_d[EW-1]};
      deg   <= (e_d == '0);
      num_x <= NW'({anx, 1'b0}) + NW'({ae, 1'b0});
      num_y <= NW'({any_, 1'b0}) + NW'({ae, 1'b0});
      den   <= {ae, 2'b00};
    end
  end

  logic [QB-1:0] q_x;
  logic [QB-1:0] q_y;
  logic          big_x;
  logic          big_y;

  tcc_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_x (
    .clk (clk), .en (en), .num (num_x), .den (den), .quo (q_x), .big (big_x)
  );

  tcc_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_y (
    .clk (clk), .en (en), .num (num_y), .den (den), .quo (q_y), .big (big_y)
  );

  logic [1:0]          neg_d;
  logic [2*W-1:0]      p1_d;
  logic                deg_d;

  tcc_delay #(.WIDTH(2), .DEPTH(TQ - T_A)) u_neg (
    .clk (clk), .en (en), .d (neg), .q (neg_d)
  );

  tcc_delay #(.WIDTH(2 * W), .DEPTH(TQ - 1)) u_p1 (
    .clk (clk), .en (en), .d ({y1, x1}), .q (p1_d)
  );

  tcc_delay #(.WIDTH(1), .DEPTH(TS - T_A)) u_deg (
    .clk (clk), .en (en), .d (deg), .q (deg_d)
  );

  // an oversized quotient stands in as 2^(W+1), enough to force both clamps
  logic [QMW-1:0]        qmx_c;
  logic [QMW-1:0]        qmy_c;
  logic signed [SMW-1:0] ux;
  logic signed [SMW-1:0] uy;
  logic [QMW-1:0]        qmx;
  logic [QMW-1:0]        qmy;
  logic signed [SMW-1:0] sumx;
  logic signed [SMW-1:0] sumy;

  always_comb begin
    qmx_c = big_x ? QBIG : QMW'(q_x);
    qmy_c = big_y ? QBIG : QMW'(q_y);
    ux    = neg_d[0] ? SMW'(0) - SMW'(qmx_c) : SMW'(qmx_c);
    uy    = neg_d[1] ? SMW'(0) - SMW'(qmy_c) : SMW'(qmy_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qmx  <= qmx_c;
      qmy  <= qmy_c;
      sumx <= SMW'($signed(p1_d[W-1:0])) + ux;
      sumy <= SMW'($signed(p1_d[2*W-1:W])) + uy;
    end
  end

  logic         ovx;
  logic         ovy;
  logic [W-1:0] cxo;
  logic [W-1:0] cyo;
  logic         csat;
  logic         rsp;

  assign ovx = !((&sumx[SMW-1:W-1]) || !(|sumx[SMW-1:W-1]));
  assign ovy = !((&sumy[SMW-1:W-1]) || !(|sumy[SMW-1:W-1]));

  always_ff @(posedge clk) begin
    if (en) begin
      cxo  <= ovx ? (sumx[SMW-1] ? CMIN : CMAX) : sumx[W-1:0];
      cyo  <= ovy ? (sumy[SMW-1] ? CMIN : CMAX) : sumy[W-1:0];
      csat <= ovx || ovy;
      rsp  <= (qmx[QMW-1:W] != '0) || (qmy[QMW-1:W] != '0);
    end
  end

  logic [2*W-1:0] sqx;
  logic [2*W-1:0] sqy;
  logic [SW-1:0]  ssum;

  tcc_mul #(.AW(W), .BW(W)) u_sq_x (
    .clk (clk), .en (en), .a (qmx[W-1:0]), .b (qmx[W-1:0]), .p (sqx)
  );

  tcc_mul #(.AW(W), .BW(W)) u_sq_y (
    .clk (clk), .en (en), .a (qmy[W-1:0]), .b (qmy[W-1:0]), .p (sqy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ssum <= SW'(sqx) + SW'(sqy);
    end
  end

  logic [RB-1:0] root;
  logic [SW-1:0] rrem;

  tcc_sqrt #(.RB(RB)) u_sqrt (
    .clk (clk), .en (en), .s (ssum), .root (root), .rem (rrem)
  );

  logic [GW-1:0] g_d;

  tcc_delay #(.WIDTH(GW), .DEPTH(TS - T_G)) u_g (
    .clk (clk), .en (en), .d ({rsp, csat, cyo, cxo}), .q (g_d)
  );

  // round to nearest: bump when the remainder passes the root
  logic [RB:0] rnd;
  logic        rsat;

  assign rnd  = (RB+1)'(root) + (RB+1)'(rrem > SW'(root));
  assign rsat = g_d[GW-1] || (rnd[RB:W] != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (deg_d) begin
        center_x   <= '0;
        center_y   <= '0;
        radius     <= '0;
        degenerate <= 1'b1;
        saturated  <= 1'b0;
      end else begin
        center_x   <= g_d[W-1:0];
        center_y   <= g_d[2*W-1:W];
        radius     <= rsat ? '1 : rnd[W-1:0];
        degenerate <= 1'b0;
        saturated  <= g_d[GW-2] || rsat;
      end
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate |->
      center_x == '0 && center_y == '0 && radius == '0 && !saturated)
    else $error("degenerate word carries nonzero fields");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    vld[TS-1] |-> rrem <= SW'({root, 1'b0}))
    else $error("square root remainder out of range");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(vld))
    else $error("pipeline moved while result stalled");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tcc_pkg::*;

  localparam int W = COORD_WIDTH_DEF;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [W-1:0] x1, y1, x2, y2, x3, y3;
  } tri_t;

  typedef struct {
    logic signed [W-1:0] cx, cy;
    logic [W-1:0] rad;
    logic deg, sat;
  } circ_t;

  typedef struct {
    tri_t t;
    logic known;
    circ_t c;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic valid = 0;
  logic stall;
  logic signed [W-1:0] p1_x = 0, p1_y = 0, p2_x = 0, p2_y = 0, p3_x = 0, p3_y = 0;
  logic result_valid;
  logic result_stall = 1;
  logic signed [W-1:0] center_x, center_y;
  logic [W-1:0] radius;
  logic degenerate, saturated;

  circ_t expected_circles[$];
  int errors = 0;
  bit send_quiet = 0;
  bit recv_quiet = 0;

  triangle_circumcircle dut (.*);

  always #1 clk = ~clk;

  function automatic wide_t div_round(wide_t n, wide_t d);
    wide_t an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic logic signed [W-1:0] clamp_coord(wide_t v, inout logic sat);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (W - 1)) - 1;
    lo = -(wide_t'(1) <<< (W - 1));
    if (v > hi) begin
      sat = 1;
      v = hi;
    end
    if (v < lo) begin
      sat = 1;
      v = lo;
    end
    return v[W-1:0];
  endfunction

  function automatic circ_t circumcircle(tri_t t);
    circ_t c;
    wide_t x1, y1, bx, by, cx, cy, d, bb, cc, ux, uy, ax, ay, s, r, tr, lim, top;
    logic sat;
    x1 = t.x1;
    y1 = t.y1;
    bx = t.x2;
    bx = bx - x1;
    by = t.y2;
    by = by - y1;
    cx = t.x3;
    cx = cx - x1;
    cy = t.y3;
    cy = cy - y1;
    d = 2 * (bx * cy - by * cx);
    c = '{default: 0};
    if (d == 0) begin
      c.deg = 1;
      return c;
    end
    sat = 0;
    bb = bx * bx + by * by;
    cc = cx * cx + cy * cy;
    ux = div_round(cy * bb - by * cc, d);
    uy = div_round(bx * cc - cx * bb, d);
    c.cx = clamp_coord(x1 + ux, sat);
    c.cy = clamp_coord(y1 + uy, sat);
    lim = wide_t'(1) <<< W;
    top = lim - 1;
    ax = (ux < 0) ? -ux : ux;
    ay = (uy < 0) ? -uy : uy;
    if (ax >= lim || ay >= lim) begin
      sat = 1;
      r = top;
    end else begin
      s = ax * ax + ay * ay;
      r = 0;
      for (int b = W; b >= 0; b--) begin
        tr = r + (wide_t'(1) <<< b);
        if (tr * tr <= s) r = tr;
      end
      if (s - r * r > r) r = r + 1;
      if (r > top) begin
        sat = 1;
        r = top;
      end
    end
    c.rad = r[W-1:0];
    c.sat = sat;
    return c;
  endfunction

  function automatic logic signed [W-1:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(2047)) - 1024;
      2: return $signed($urandom_range(32'h7ffff)) - 32'sh40000;
      default: return $urandom_range(1) ? 32'sh7fff_ffff - $urandom_range(255)
                                        : 32'sh8000_0000 + $urandom_range(255);
    endcase
  endfunction

  function automatic tri_t rnd_triangle();
    tri_t t;
    int mode, k;
    mode = $urandom_range(3);
    t.x1 = rnd_coord(mode);
    t.y1 = rnd_coord(mode);
    t.x2 = rnd_coord(mode);
    t.y2 = rnd_coord(mode);
    t.x3 = rnd_coord(mode);
    t.y3 = rnd_coord(mode);
    case ($urandom_range(9))
      0: begin
        // collinear, third point on the line through the first two
        k = $signed($urandom_range(6)) - 3;
        t.x3 = t.x1 + k * (t.x2 - t.x1);
        t.y3 = t.y1 + k * (t.y2 - t.y1);
      end
      1: begin
        // nearly collinear, huge circle
        t.x3 = t.x2 + (t.x2 - t.x1);
        t.y3 = t.y2 + (t.y2 - t.y1) + $signed($urandom_range(2)) - 1;
      end
      2: begin
        t.x2 = t.x1;
        t.y2 = t.y1;
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_word(tri_t t, logic known, circ_t c);
    @(negedge clk);
    while (!send_quiet && $urandom_range(99) < 23) begin
      valid = 0;
      @(negedge clk);
    end
    valid = 1;
    {p1_x, p1_y, p2_x, p2_y, p3_x, p3_y} = {t.x1, t.y1, t.x2, t.y2, t.x3, t.y3};
    do @(posedge clk); while (stall);
    expected_circles.push_back(known ? c : circumcircle(t));
  endtask

  always @(negedge clk)
    if (!rst) result_stall = recv_quiet ? 0 : ($urandom_range(99) < 23);

  always @(posedge clk) begin
    circ_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_circles.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h %h %h", center_x, center_y, radius);
      end else begin
        e = expected_circles.pop_front();
        if (center_x !== e.cx || center_y !== e.cy || radius !== e.rad ||
            degenerate !== e.deg || saturated !== e.sat) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %h %h %h d%b s%b got %h %h %h d%b s%b",
                     e.cx, e.cy, e.rad, e.deg, e.sat,
                     center_x, center_y, radius, degenerate, saturated);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    row_t rows[$];
    circ_t z, one;
    tri_t t;
    localparam logic signed [W-1:0] MX = 32'sh7fff_ffff;
    localparam logic signed [W-1:0] MN = 32'sh8000_0000;
    z = '{default: 0};
    z.deg = 1;
    one = '{cx: 1, cy: 1, rad: 1, deg: 0, sat: 0};
    rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, z});
    rows.push_back('{'{MX, MN, MX, MN, MX, MN}, 1, z});
    rows.push_back('{'{MN, MN, 0, 0, MX, MX}, 0, z});
    rows.push_back('{'{0, 0, 2, 0, 0, 2}, 1, one});
    rows.push_back('{'{1, 1, 1, 5, 1, -7}, 1, z});
    rows.push_back('{'{MN, MN, MX, MN, MN, MX}, 0, z});
    rows.push_back('{'{MX, MX, MN, MX, MX, MN}, 0, z});
    rows.push_back('{'{MN, 0, MX, 0, 0, MX}, 0, z});
    rows.push_back('{'{0, 0, 1, 0, 0, 1}, 0, z});
    rows.push_back('{'{0, 0, 1, 1, 2, 3}, 0, z});
    rows.push_back('{'{MX, 0, MX, 1, MX - 1, 0}, 0, z});
    rows.push_back('{'{MN, MN, MN + 1, MN, MX, MX - 1}, 0, z});
    rows.push_back('{'{-1, -1, 32'sh10000, 0, 0, 32'sh10000}, 0, z});
    rows.push_back('{'{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, -3, 7,
                       32'sh0fff_0000}, 0, z});
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (rows[i]) send_word(rows[i].t, rows[i].known, rows[i].c);
    for (int n = 0; n < 800; n++) begin
      send_quiet = (n >= 300 && n < 450);
      recv_quiet = send_quiet;
      if (n == 500) begin
        // hold the sender off until the pipe drains
        @(negedge clk);
        valid = 0;
        while (expected_circles.size() != 0) @(negedge clk);
      end
      t = rnd_triangle();
      send_word(t, 0, z);
    end
    @(negedge clk);
    valid = 0;
    while (expected_circles.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_circles.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tcc_pkg.sv
rtl/tcc_delay.sv
rtl/tcc_mul.sv
rtl/tcc_div.sv
rtl/tcc_sqrt.sv
rtl/triangle_circumcircle.sv
tb/testbench.sv
